// File: rtl/nvtlv_pkg.sv
// Package for the nested varint TLV parser.
// Request structs, event and config register codes, sizing constants. No dependencies.
`timescale 1ns / 1ps

package nvtlv_pkg;

  localparam int ID_BYTES = 32;
  localparam int MAX_NEST = 8;
  localparam int LEN_BITS = 16;
  localparam int OFS_W = 17;
  localparam int LVL_W = 4;

  localparam logic [3:0] EV_HEADER = 4'd0;
  localparam logic [3:0] EV_KEY    = 4'd1;
  localparam logic [3:0] EV_DATA   = 4'd2;
  localparam logic [3:0] EV_CLOSE  = 4'd3;
  localparam logic [3:0] EV_ID     = 4'd4;
  localparam logic [3:0] EV_DONE   = 4'd5;
  localparam logic [3:0] EV_EMPTY  = 4'd6;
  localparam logic [3:0] EV_NEED   = 4'd7;
  localparam logic [3:0] EV_ERROR  = 4'd8;

  localparam logic [1:0] CFG_KEY    = 2'd0;
  localparam logic [1:0] CFG_SIGNED = 2'd1;
  localparam logic [1:0] CFG_NESTED = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_buffer;
    logic [15:0] buffer_length;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [30:0] attr_type;
    logic [3:0]  nest_level;
    logic        key_present;
    logic        is_signed;
    logic        is_nested;
    logic [15:0] key_length;
    logic [15:0] data_length;
    logic [7:0]  byte_value;
    logic [15:0] bytes_consumed;
    logic        last_of_run;
  } out_req_t;

  function automatic out_req_t simple_ev(logic [3:0] kind, logic [3:0] lvl,
                                         logic [7:0] bv, logic [15:0] bc);
    out_req_t o;
    o = '0;
    o.event_kind = kind;
    o.nest_level = lvl;
    o.byte_value = bv;
    o.bytes_consumed = bc;
    return o;
  endfunction

endpackage

// File: rtl/nested_varint_tlv_parser.sv
// Nested varint TLV parser, one buffer byte per input request.
// Depends on nvtlv_pkg and nvtlv_varint. Holds the set end stack.
`timescale 1ns / 1ps

// Takes one byte per request and emits up to ten events for it, one per
// cycle while the receiver is ready, from a small sequencer that reuses
// one compare against the set end stack for every close. The input is not
// ready while a byte's events are pending or not yet taken. A byte that
// only feeds a varint leaves the input ready for the next byte. A byte
// that gives events presents them in order and waits for the last to be
// taken; each closed set is one of those events; stalls pause the sequencer.
module nested_varint_tlv_parser
  import nvtlv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  in_req_t  in_data,
  input  logic     in_valid,
  output logic     in_ready,
  output out_req_t out_data,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam logic [3:0] PH_LEN = 4'd0, PH_ID = 4'd1, PH_TYPE = 4'd2,
    PH_FLAGS = 4'd3, PH_KEYLEN = 4'd4, PH_KEY = 4'd5, PH_DATALEN = 4'd6,
    PH_DATA = 4'd7, PH_IDLE = 4'd8;

  localparam logic [2:0] SQ_IN = 3'd0, SQ_EV = 3'd1, SQ_CLOSE = 3'd2, SQ_DONE = 3'd3,
    SQ_KERR = 3'd4, SQ_FOLD = 3'd5;

  logic [4:0] key_bit, sgn_bit, nst_bit;
  logic [2:0] sq, sq_next;
  logic [3:0] phase, phase_next;
  logic [OFS_W-1:0] ofs, ofs_next, msg_end, msg_end_next, left, left_next;
  logic [OFS_W-1:0] stk [MAX_NEST];
  logic [LVL_W-1:0] lvl, lvl_next;
  logic [30:0] h_type, h_type_next, h_flags, h_flags_next;
  logic [15:0] h_klen, h_klen_next;
  out_req_t ev, ev_next, err_ev;
  logic ev_last, ev_last_next;
  logic out_valid_next;
  logic stk_we;
  logic [OFS_W-1:0] top_end;

  logic v_clear, v_step, v_bad, v_more;
  logic [63:0] v_val;

  logic acc;
  logic [3:0] ph0;
  logic [OFS_W-1:0] cur_end, ofs0, ofs1, blen, fld_end;
  logic hi_bad, len_big, len_out, tail_more, close_more;
  logic [31:0] flags_w;
  logic kp, sg, ns;

  nvtlv_varint u_var (
    .clk(clk), .rst(rst), .clear(v_clear), .step(v_step), .din(in_data.data_byte),
    .bad(v_bad), .more(v_more), .value(v_val)
  );

  assign in_ready = (sq == SQ_IN) && !out_valid;
  assign acc = in_valid && in_ready;
  assign v_clear = acc && in_data.first_of_buffer;
  assign top_end = stk[lvl[2:0] - 3'd1];

  assign ph0 = in_data.first_of_buffer ? PH_LEN : phase;
  assign cur_end = (lvl == '0) ? msg_end : top_end;
  assign ofs0 = in_data.first_of_buffer ? '0 : ofs;
  assign ofs1 = ofs0 + OFS_W'(1);
  assign blen = {1'b0, in_data.buffer_length};
  assign fld_end = ofs1 + {1'b0, v_val[15:0]};
  assign hi_bad = |v_val[63:31];
  assign len_big = |v_val[63:LEN_BITS];
  assign len_out = ofs0 >= blen;
  assign v_step = acc && ((ph0 == PH_LEN) ? !len_out :
                  (ph0 inside {PH_TYPE, PH_FLAGS, PH_KEYLEN, PH_DATALEN}));

  // after the pending event: a close or done follows
  assign tail_more = (lvl != '0) ? (ofs >= top_end) : (ofs >= msg_end);
  // after closing set lvl: another close or done follows
  assign close_more = (lvl != LVL_W'(1)) ? (ofs >= stk[lvl[2:0] - 3'd2]) :
                      (ofs >= msg_end);

  assign flags_w = {1'b0, h_flags};
  assign kp = flags_w[key_bit];
  assign sg = flags_w[sgn_bit];
  assign ns = flags_w[nst_bit];
  assign err_ev = simple_ev(EV_ERROR, lvl, 8'd0, 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bit <= 5'd0;
      sgn_bit <= 5'd1;
      nst_bit <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY:    key_bit <= cfg_wdata;
        CFG_SIGNED: sgn_bit <= cfg_wdata;
        CFG_NESTED: nst_bit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sq_next = sq;
    phase_next = phase;
    ofs_next = ofs;
    msg_end_next = msg_end;
    left_next = left;
    lvl_next = lvl;
    h_type_next = h_type;
    h_flags_next = h_flags;
    h_klen_next = h_klen;
    ev_next = ev;
    ev_last_next = ev_last;
    out_valid_next = out_valid && !out_ready;
    stk_we = 1'b0;
    case (sq)
      SQ_IN: begin
        if (acc) begin
          if (in_data.first_of_buffer) begin
            lvl_next = '0;
            msg_end_next = '0;
            left_next = '0;
            h_type_next = '0;
            h_flags_next = '0;
            h_klen_next = '0;
          end
          phase_next = ph0;
          ev_last_next = 1'b1;
          case (ph0)
            PH_IDLE: ;
            PH_LEN: begin
              if (len_out) begin
                ev_next = simple_ev(EV_NEED, 4'd0, 8'd0, 16'd0); sq_next = SQ_EV;
                phase_next = PH_IDLE;
              end else begin
                ofs_next = ofs1;
                if (v_bad) begin
                  ev_next = simple_ev(EV_ERROR, 4'd0, 8'd0, 16'd0); sq_next = SQ_EV;
                  phase_next = PH_IDLE;
                end else if (v_more) begin
                  if (ofs1 >= blen) begin
                    ev_next = simple_ev(EV_NEED, 4'd0, 8'd0, 16'd0); sq_next = SQ_EV;
                    phase_next = PH_IDLE;
                  end
                end else if (v_val == 64'd0) begin
                  ev_next = simple_ev(EV_EMPTY, 4'd0, 8'd0, ofs1[15:0]); sq_next = SQ_EV;
                  phase_next = PH_IDLE;
                end else if (len_big) begin
                  ev_next = simple_ev(EV_ERROR, 4'd0, 8'd0, 16'd0); sq_next = SQ_EV;
                  phase_next = PH_IDLE;
                end else begin
                  msg_end_next = fld_end;
                  if (fld_end > blen || v_val[15:0] < 16'(ID_BYTES)) begin
                    ev_next = simple_ev(EV_NEED, 4'd0, 8'd0, 16'd0); sq_next = SQ_EV;
                    phase_next = PH_IDLE;
                  end else begin
                    left_next = OFS_W'(ID_BYTES);
                    phase_next = PH_ID;
                  end
                end
              end
            end
            PH_ID: begin
              ofs_next = ofs1;
              ev_next = simple_ev(EV_ID, 4'd0, in_data.data_byte, 16'd0);
              left_next = left - OFS_W'(1);
              if (left == OFS_W'(1)) begin
                phase_next = PH_TYPE; sq_next = SQ_CLOSE;
              end else sq_next = SQ_EV;
            end
            PH_KEY: begin
              ofs_next = ofs1;
              ev_next = simple_ev(EV_KEY, lvl, in_data.data_byte, 16'd0);
              left_next = left - OFS_W'(1);
              sq_next = SQ_EV;
              if (left == OFS_W'(1)) begin
                phase_next = PH_DATALEN;
                if (ofs1 >= cur_end) sq_next = SQ_DONE;
              end
            end
            PH_DATA: begin
              ofs_next = ofs1;
              ev_next = simple_ev(EV_DATA, lvl, in_data.data_byte, 16'd0);
              left_next = left - OFS_W'(1);
              if (left == OFS_W'(1)) begin
                phase_next = PH_TYPE; sq_next = SQ_CLOSE;
              end else sq_next = SQ_EV;
            end
            default: begin
              ofs_next = ofs1;
              if (v_bad) begin
                ev_next = err_ev; sq_next = SQ_EV; phase_next = PH_IDLE;
              end else if (v_more) begin
                if (ofs1 >= cur_end) begin
                  ev_next = err_ev; sq_next = SQ_EV; phase_next = PH_IDLE;
                end
              end else if (ph0 == PH_TYPE || ph0 == PH_FLAGS) begin
                if (hi_bad) begin
                  ev_next = err_ev; sq_next = SQ_EV; phase_next = PH_IDLE;
                end else begin
                  if (ph0 == PH_TYPE) begin
                    h_type_next = v_val[30:0]; phase_next = PH_FLAGS;
                  end else begin
                    h_flags_next = v_val[30:0];
                    if (v_val[key_bit]) phase_next = PH_KEYLEN;
                    else begin h_klen_next = '0; phase_next = PH_DATALEN; end
                  end
                  if (ofs1 >= cur_end) begin
                    ev_next = err_ev; sq_next = SQ_EV; phase_next = PH_IDLE;
                  end
                end
              end else if (len_big || {1'b0, v_val[15:0]} > cur_end - ofs1) begin
                ev_next = err_ev; sq_next = SQ_EV; phase_next = PH_IDLE;
              end else if (ph0 == PH_KEYLEN) begin
                h_klen_next = v_val[15:0];
                if (v_val[15:0] != 16'd0) begin
                  left_next = {1'b0, v_val[15:0]}; phase_next = PH_KEY;
                end else begin
                  phase_next = PH_DATALEN;
                  if (ofs1 >= cur_end) begin
                    ev_next = err_ev; sq_next = SQ_EV; phase_next = PH_IDLE;
                  end
                end
              end else if (ns && lvl >= LVL_W'(MAX_NEST)) begin
                ev_next = err_ev; sq_next = SQ_EV; phase_next = PH_IDLE;
              end else begin
                ev_next = '0;
                ev_next.event_kind = EV_HEADER;
                ev_next.attr_type = h_type;
                ev_next.nest_level = lvl;
                ev_next.key_present = kp;
                ev_next.is_signed = sg;
                ev_next.is_nested = ns;
                ev_next.key_length = kp ? h_klen : 16'd0;
                ev_next.data_length = v_val[15:0];
                if (ns) begin
                  stk_we = 1'b1;
                  lvl_next = lvl + LVL_W'(1);
                  phase_next = PH_TYPE;
                  sq_next = SQ_CLOSE;
                end else if (v_val[15:0] != 16'd0) begin
                  left_next = {1'b0, v_val[15:0]}; phase_next = PH_DATA;
                  sq_next = SQ_EV;
                end else begin
                  phase_next = PH_TYPE; sq_next = SQ_CLOSE;
                end
              end
            end
          endcase
        end
      end
      SQ_EV: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          sq_next = SQ_IN;
        end
      end
      SQ_CLOSE: begin
        // pending byte or header goes out; closes or done may follow
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          ev_last_next = !tail_more;
          sq_next = tail_more ? SQ_FOLD : SQ_IN;
        end
      end
      SQ_DONE: begin
        // key end hit set end: key byte then error
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          ev_last_next = 1'b0;
          sq_next = SQ_KERR;
        end
      end
      SQ_KERR: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          ev_next = err_ev;
          ev_last_next = 1'b1;
          phase_next = PH_IDLE;
          sq_next = SQ_IN;
        end
      end
      SQ_FOLD: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          if (lvl != '0) begin
            ev_next = simple_ev(EV_CLOSE, lvl, 8'd0, 16'd0);
            lvl_next = lvl - LVL_W'(1);
            ev_last_next = !close_more;
            sq_next = close_more ? SQ_FOLD : SQ_IN;
          end else begin
            ev_next = simple_ev(EV_DONE, 4'd0, 8'd0, msg_end[15:0]);
            ev_last_next = 1'b1;
            phase_next = PH_IDLE;
            sq_next = SQ_IN;
          end
        end
      end
      default: sq_next = SQ_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq <= SQ_IN;
      phase <= PH_LEN;
      ofs <= '0;
      msg_end <= '0;
      left <= '0;
      lvl <= '0;
      h_type <= '0;
      h_flags <= '0;
      h_klen <= '0;
      out_valid <= 1'b0;
      ev <= '0;
      ev_last <= 1'b0;
    end else begin
      sq <= sq_next;
      phase <= phase_next;
      ofs <= ofs_next;
      msg_end <= msg_end_next;
      left <= left_next;
      lvl <= lvl_next;
      h_type <= h_type_next;
      h_flags <= h_flags_next;
      h_klen <= h_klen_next;
      out_valid <= out_valid_next;
      ev <= ev_next;
      ev_last <= ev_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && stk_we) stk[lvl[2:0]] <= fld_end;
  end

  always_comb begin
    out_data = ev;
    out_data.last_of_run = ev_last;
  end

endmodule

// File: rtl/nvtlv_varint.sv
// Varint accumulator: folds one byte per request into a 64-bit value.
// Depends on nvtlv_pkg.
`timescale 1ns / 1ps

module nvtlv_varint
  import nvtlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        step,
  input  logic [7:0]  din,
  output logic        bad,
  output logic        more,
  output logic [63:0] value
);

  logic [63:0] acc;
  logic [3:0]  cnt;
  logic [3:0]  cnt_cur;
  logic [3:0]  cnt_next;
  logic        first;

  // a restart counts the byte that comes with it as the first varint byte
  assign cnt_cur = clear ? 4'd0 : cnt;
  assign first = (cnt_cur == 4'd0);
  assign value = {(first ? 57'd0 : acc[56:0]), din[6:0]};
  assign more = din[7];
  assign cnt_next = cnt_cur + 4'd1;
  assign bad = (first && din == 8'h80) || (din[7] && cnt_next >= 4'd10);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      acc <= '0;
    end else if (step) begin
      acc <= value;
      cnt <= din[7] ? cnt_next : 4'd0;
    end else if (clear) begin
      cnt <= '0;
      acc <= '0;
    end
  end

endmodule

// File: rtl/nvtlv_checker.sv
// Port-level checks for the nested varint TLV parser.
// Depends on nvtlv_pkg; bound to nested_varint_tlv_parser.
`timescale 1ns / 1ps

module nvtlv_checker
  import nvtlv_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input out_req_t out_data,
  input logic     out_valid,
  input logic     out_ready
);

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request dropped while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready with result pending");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.event_kind <= EV_ERROR)
    else $error("bad event kind");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_kind == EV_DONE || out_data.event_kind == EV_ERROR)
    |-> out_data.last_of_run)
    else $error("terminal event not last");

endmodule

bind nested_varint_tlv_parser nvtlv_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);

// File: test/tb.sv
// Testbench for nested_varint_tlv_parser: byte requests in, event requests out.
// Uses nvtlv_pkg for the payload structs and event/register codes; predicts
// every event in-line and checks each one in order.
`timescale 1ns / 1ps

module tb;
  import nvtlv_pkg::*;

  typedef logic [7:0] bytes_t[$];
  typedef enum int {P_LEN, P_ID, P_TYPE, P_FLAGS, P_KEYLEN, P_KEY, P_DATALEN, P_DATA,
                    P_IDLE} parse_ph_t;

  logic     clk = 0;
  logic     rst = 1;
  in_req_t  in_data = '0;
  logic     in_valid = 0;
  logic     in_ready;
  out_req_t out_data;
  logic     out_valid;
  logic     out_ready = 0;
  logic     cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_wdata = '0;

  nested_varint_tlv_parser u_top (.*);

  always #5 clk = ~clk;

  // parser state mirror
  logic [4:0]  key_bit = 0, sign_bit = 1, nest_bit = 2;
  logic [63:0] ofs, acc, msg_end, fleft, htype, hflags, hkeylen;
  logic [63:0] set_end[0:MAX_NEST];
  parse_ph_t   phase;
  int          vcnt, lvl;

  out_req_t event_q[$];
  out_req_t step_q[$];
  int mismatches = 0, n_events = 0, n_reqs = 0, n_bufs = 0;
  int idle_mode = 0, hold = 0;

  function automatic out_req_t mk_ev(logic [3:0] kind, int l, logic [7:0] bv,
                                     logic [15:0] bc);
    out_req_t o;
    o = '0;
    o.event_kind = kind;
    o.nest_level = l[3:0];
    o.byte_value = bv;
    o.bytes_consumed = bc;
    return o;
  endfunction

  function automatic void stop_parse(logic [3:0] kind);
    step_q.push_back(mk_ev(kind, kind == EV_ERROR ? lvl : 0, 0, 0));
    phase = P_IDLE;
  endfunction

  function automatic int feed(logic [7:0] b);
    if (vcnt == 0) begin
      if (b == 8'h80) return -1;
      acc = 0;
    end
    acc = (acc << 7) | {57'd0, b[6:0]};
    vcnt++;
    if (b[7]) begin
      if (vcnt >= 10) return -1;
      return 0;
    end
    vcnt = 0;
    return 1;
  endfunction

  function automatic void restart_parse();
    ofs = 0; phase = P_LEN; acc = 0; vcnt = 0; msg_end = 0; lvl = 0;
    fleft = 0; htype = 0; hflags = 0; hkeylen = 0;
    for (int i = 0; i <= MAX_NEST; i++) set_end[i] = 0;
  endfunction

  function automatic void predict_events(in_req_t r);
    logic [7:0]  b;
    logic [63:0] blen, cur_end, v;
    int          res;
    bit          at_boundary;
    logic        kp, sg, ns;
    out_req_t    h;
    b = r.data_byte;
    blen = {48'd0, r.buffer_length};
    at_boundary = 0;
    step_q.delete();
    if (r.first_of_buffer) restart_parse();
    if (phase == P_IDLE) return;
    if (lvl > MAX_NEST) lvl = MAX_NEST;
    cur_end = lvl != 0 ? set_end[lvl-1] : msg_end;
    case (phase)
      P_LEN: begin
        if (ofs >= blen) stop_parse(EV_NEED);
        else begin
          ofs++;
          res = feed(b);
          if (res < 0) stop_parse(EV_ERROR);
          else if (res == 0) begin
            if (ofs >= blen) stop_parse(EV_NEED);
          end else begin
            v = acc;
            if (v == 0) begin
              step_q.push_back(mk_ev(EV_EMPTY, 0, 0, ofs[15:0]));
              phase = P_IDLE;
            end else if ((v >> LEN_BITS) != 0) stop_parse(EV_ERROR);
            else begin
              msg_end = ofs + v;
              if (msg_end > blen || v < ID_BYTES) stop_parse(EV_NEED);
              else begin
                fleft = ID_BYTES;
                phase = P_ID;
              end
            end
          end
        end
      end
      P_ID: begin
        ofs++;
        step_q.push_back(mk_ev(EV_ID, 0, b, 0));
        if (--fleft == 0) phase = P_TYPE;
        at_boundary = 1;
      end
      P_KEY: begin
        ofs++;
        step_q.push_back(mk_ev(EV_KEY, lvl, b, 0));
        if (--fleft == 0) begin
          phase = P_DATALEN;
          if (ofs >= cur_end) stop_parse(EV_ERROR);
        end
      end
      P_DATA: begin
        ofs++;
        step_q.push_back(mk_ev(EV_DATA, lvl, b, 0));
        if (--fleft == 0) phase = P_TYPE;
        at_boundary = 1;
      end
      default: begin
        ofs++;
        res = feed(b);
        if (res < 0) stop_parse(EV_ERROR);
        else if (res == 0) begin
          if (ofs >= cur_end) stop_parse(EV_ERROR);
        end else begin
          v = acc;
          if (phase == P_TYPE || phase == P_FLAGS) begin
            if (v > 64'h7fff_ffff) stop_parse(EV_ERROR);
            else begin
              if (phase == P_TYPE) begin
                htype = v;
                phase = P_FLAGS;
              end else begin
                hflags = v;
                if (hflags[key_bit]) phase = P_KEYLEN;
                else begin
                  hkeylen = 0;
                  phase = P_DATALEN;
                end
              end
              if (ofs >= cur_end) stop_parse(EV_ERROR);
            end
          end else if ((v >> LEN_BITS) != 0 || v > cur_end - ofs) stop_parse(EV_ERROR);
          else if (phase == P_KEYLEN) begin
            hkeylen = v;
            if (v > 0) begin
              fleft = v;
              phase = P_KEY;
            end else begin
              phase = P_DATALEN;
              if (ofs >= cur_end) stop_parse(EV_ERROR);
            end
          end else begin
            kp = hflags[key_bit];
            sg = hflags[sign_bit];
            ns = hflags[nest_bit];
            if (ns && lvl >= MAX_NEST) stop_parse(EV_ERROR);
            else begin
              h = mk_ev(EV_HEADER, lvl, 0, 0);
              h.attr_type = htype[30:0];
              h.key_present = kp;
              h.is_signed = sg;
              h.is_nested = ns;
              h.key_length = kp ? hkeylen[15:0] : 16'd0;
              h.data_length = v[15:0];
              step_q.push_back(h);
              if (ns) begin
                set_end[lvl] = ofs + v;
                lvl++;
                phase = P_TYPE;
              end else if (v > 0) begin
                fleft = v;
                phase = P_DATA;
              end else phase = P_TYPE;
              at_boundary = 1;
            end
          end
        end
      end
    endcase
    if (at_boundary && phase == P_TYPE && vcnt == 0) begin
      while (lvl > 0 && ofs >= set_end[lvl-1]) begin
        step_q.push_back(mk_ev(EV_CLOSE, lvl, 0, 0));
        lvl--;
      end
      if (lvl == 0 && ofs >= msg_end) begin
        step_q.push_back(mk_ev(EV_DONE, 0, 0, msg_end[15:0]));
        phase = P_IDLE;
      end
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last_of_run = 1;
    foreach (step_q[i]) event_q.push_back(step_q[i]);
  endfunction

  // ---- stimulus helpers ----
  function automatic void put_varint(ref bytes_t q, input logic [63:0] v);
    int n;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--)
      q.push_back(8'((v >> (7 * i)) & 64'h7f) | (i != 0 ? 8'h80 : 8'h00));
  endfunction

  function automatic bytes_t gen_attrs(int depth, int n_attrs);
    bytes_t q, inner;
    logic [63:0] flags;
    int klen, dlen;
    for (int a = 0; a < n_attrs; a++) begin
      inner.delete();
      flags = {33'd0, 31'($urandom)};
      flags[key_bit] = $urandom_range(0, 1);
      flags[nest_bit] = (depth < 3) && ($urandom_range(0, 2) == 0);
      put_varint(q, $urandom_range(0, 1) ? 64'($urandom_range(0, 200))
                                          : {33'd0, 31'($urandom)});
      put_varint(q, flags);
      if (flags[key_bit]) begin
        klen = $urandom_range(0, 3);
        put_varint(q, klen);
        repeat (klen) q.push_back(8'($urandom));
      end
      if (flags[nest_bit]) inner = gen_attrs(depth + 1, $urandom_range(0, 2));
      else begin
        dlen = $urandom_range(0, 4);
        repeat (dlen) inner.push_back(8'($urandom));
      end
      put_varint(q, inner.size());
      q = {q, inner};
    end
    return q;
  endfunction

  // nested chain of the given depth, innermost set empty
  function automatic bytes_t nest_chain(int depth);
    bytes_t q, inner;
    logic [63:0] flags;
    if (depth == 0) return q;
    inner = nest_chain(depth - 1);
    flags = 0;
    flags[nest_bit] = 1;
    put_varint(q, depth);
    put_varint(q, flags);
    if (flags[key_bit]) put_varint(q, 0);
    put_varint(q, inner.size());
    return {q, inner};
  endfunction

  function automatic bytes_t wrap_record(bytes_t attrs);
    bytes_t q;
    put_varint(q, ID_BYTES + attrs.size());
    repeat (ID_BYTES) q.push_back(8'($urandom));
    return {q, attrs};
  endfunction

  task automatic send_req(in_req_t r);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 53 : (idle_mode == 3) ? 15 : 0;
    if ($urandom_range(1, 100) <= gap_pct) begin
      @(negedge clk) in_valid = 0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    in_data = r;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    predict_events(r);
    n_reqs++;
  endtask

  task automatic send_buf(bytes_t q, int blen);
    in_req_t r;
    foreach (q[i]) begin
      r.data_byte = q[i];
      r.first_of_buffer = (i == 0);
      r.buffer_length = blen[15:0];
      send_req(r);
    end
    n_bufs++;
  endtask

  task automatic settle();
    @(negedge clk) in_valid = 0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_flag_bits(logic [4:0] k, logic [4:0] s, logic [4:0] n);
    settle();
    @(negedge clk) begin cfg_we = 1; cfg_index = CFG_KEY;    cfg_wdata = k; end
    @(negedge clk) begin cfg_index = CFG_SIGNED; cfg_wdata = s; end
    @(negedge clk) begin cfg_index = CFG_NESTED; cfg_wdata = n; end
    @(negedge clk) cfg_we = 0;
    key_bit = k; sign_bit = s; nest_bit = n;
  endtask

  // ---- tests ----
  task automatic test_length_prefix();
    bytes_t q;
    send_buf('{8'h00}, 1);
    send_buf('{8'h80, 8'h01}, 5);
    q.delete(); repeat (10) q.push_back(8'h81);
    send_buf(q, 12);
    send_buf('{8'h84, 8'h80, 8'h00}, 65535);
    send_buf('{8'h81}, 1);
    send_buf('{8'h05, 8'hff}, 10);
    send_buf('{8'd40, 8'h00}, 20);
  endtask

  task automatic test_attr_errors();
    bytes_t a, rec;
    a.delete(); put_varint(a, 64'h8000_0000); put_varint(a, 0); put_varint(a, 0);
    rec = wrap_record(a); send_buf(rec, rec.size());
    a.delete(); put_varint(a, 64'h7fff_ffff); put_varint(a, 64'h7fff_ffff);
    put_varint(a, 50); a.push_back(8'h00);
    rec = wrap_record(a); send_buf(rec, 65535);
    rec = wrap_record(nest_chain(MAX_NEST + 1)); send_buf(rec, rec.size());
    a.delete(); put_varint(a, 1);
    rec = wrap_record(a); send_buf(rec, rec.size());
  endtask

  task automatic test_deep_close();
    bytes_t a, rec;
    a = nest_chain(MAX_NEST);
    put_varint(a, 0); put_varint(a, 0); put_varint(a, 2);
    a.push_back(8'h00); a.push_back(8'hff);
    rec = wrap_record(a);
    send_buf(rec, rec.size() + 3);
  endtask

  task automatic test_random_records(int n_bytes, bit with_hold);
    bytes_t rec;
    int blen, sent0, pos;
    sent0 = n_reqs;
    while (n_reqs - sent0 < n_bytes) begin
      rec = wrap_record(gen_attrs(0, $urandom_range(1, 3)));
      blen = rec.size();
      case ($urandom_range(0, 9))
        0: rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom);
        1: blen = $urandom_range(1, rec.size());
        2, 3: blen = $urandom_range(rec.size(), 65535);
        4: begin
          pos = $urandom_range(ID_BYTES + 1, rec.size() - 1);
          rec[pos] = rec[pos] | 8'h80;
        end
        default: ;
      endcase
      if (with_hold && n_reqs - sent0 < 40) hold = 300;
      send_buf(rec, blen);
    end
  endtask

  // ---- receiver and checker ----
  always @(negedge clk) begin
    if (hold > 0) begin
      out_ready = 0;
      hold--;
    end else
      out_ready = (idle_mode == 2) ? ($urandom_range(1, 100) > 53) :
                  (idle_mode == 3) ? ($urandom_range(1, 100) > 15) : 1'b1;
  end

  always @(posedge clk) begin
    out_req_t e;
    if (!rst && out_valid && out_ready) begin
      n_events++;
      if (event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %p", out_data);
      end else begin
        e = event_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p\n          actual   %p",
                                         e, out_data);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("nested_varint_tlv_parser test failed");
    $finish;
  end

  initial begin
    restart_parse();
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 0;
    test_length_prefix();
    test_attr_errors();
    test_deep_close();
    idle_mode = 0;
    test_random_records(10, 1);
    write_flag_bits(5'd30, 5'd29, 5'd28);
    idle_mode = 1;
    test_random_records(10, 0);
    write_flag_bits(5'd7, 5'd30, 5'd0);
    idle_mode = 2;
    test_random_records(10, 0);
    write_flag_bits(5'd13, 5'd0, 5'd30);
    idle_mode = 3;
    test_random_records(10, 0);
    settle();
    $display("%0d byte requests in %0d buffers, %0d events checked, %0d mismatches",
             n_reqs, n_bufs, n_events, mismatches);
    $display("covered length prefix errors, id, keys, nesting to max depth, four flag maps");
    if (mismatches == 0 && event_q.size() == 0)
      $display("nested_varint_tlv_parser test passed");
    else
      $display("nested_varint_tlv_parser test failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/nvtlv_pkg.sv
rtl/nvtlv_varint.sv
rtl/nested_varint_tlv_parser.sv
rtl/nvtlv_checker.sv
test/tb.sv
